// ===== hw/rtl/sst_pkg.sv =====
// ----------------------------------------------------------------------------
// sst_pkg: shared types and constants for the safe zone stop tracker
// Payload structs, register indexes and cell control struct.
// ----------------------------------------------------------------------------
package sst_pkg;

    localparam int PriceW = 31;
    localparam int StopW  = 32;

    // configuration register indexes
    localparam logic [1:0] REG_LOOKBACK = 2'd0;
    localparam logic [1:0] REG_HOLD     = 2'd1;
    localparam logic [1:0] REG_COEF     = 2'd2;
    localparam logic [1:0] REG_SIDE     = 2'd3;

    typedef struct packed {
        logic [PriceW-1:0] bar_low;
        logic [PriceW-1:0] bar_high;
        logic              series_start;
    } t_in_item;

    typedef struct packed {
        logic signed [StopW-1:0] stop_level;
        logic signed [StopW-1:0] raw_stop;
    } t_out_item;

    // control broadcast to the penetration cells
    typedef struct packed {
        logic shift;
        logic rotate;
    } t_cell_ctl;

endpackage

// ===== hw/rtl/sst_pen_cell.sv =====
// ----------------------------------------------------------------------------
// sst_pen_cell: one stage of the penetration delay line
// Holds one down and one up penetration and hands them to its neighbor.
// On shift a new sample enters from the left; on rotate the line circulates
// (used to sweep the window past the accumulator).
// ----------------------------------------------------------------------------
module sst_pen_cell #(
    parameter int W = 31
) (
    input  logic             i_clk,
    input  sst_pkg::t_cell_ctl i_ctl,
    input  logic [W-1:0]     i_dn,
    input  logic [W-1:0]     i_up,
    output logic [W-1:0]     o_dn,
    output logic [W-1:0]     o_up
);
    logic [W-1:0] r_dn, r_up;

    // stage register, moves on shift or rotate
    always_ff @(posedge i_clk) begin
        if (i_ctl.shift || i_ctl.rotate) begin
            r_dn <= i_dn;
            r_up <= i_up;
        end
    end

    assign o_dn = r_dn;
    assign o_up = r_up;
endmodule

// ===== hw/rtl/sst_divider.sv =====
// ----------------------------------------------------------------------------
// sst_divider: restoring bit-serial unsigned divider
// One quotient bit per cycle; result valid in o_done pulse.
// ----------------------------------------------------------------------------
module sst_divider #(
    parameter int NW = 42,
    parameter int DW = 11
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [NW-1:0] i_num,
    input  logic [DW-1:0] i_den,
    output logic          o_done,
    output logic [NW-1:0] o_quot
);
    localparam int CW = $clog2(NW + 1);

    logic [NW-1:0] r_q;
    logic [DW:0]   r_rem;
    logic [DW-1:0] r_den;
    logic [CW-1:0] r_cnt;
    logic          r_busy, r_done;
    logic [DW:0]   n_trial;

    assign n_trial = {r_rem[DW-1:0], r_q[NW-1]};

    // one quotient bit per cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_q    <= i_num;
                r_rem  <= '0;
                r_den  <= i_den;
                r_cnt  <= CW'(NW);
            end else if (r_busy) begin
                if (n_trial >= {1'b0, r_den}) begin
                    r_rem <= n_trial - {1'b0, r_den};
                    r_q   <= {r_q[NW-2:0], 1'b1};
                end else begin
                    r_rem <= n_trial;
                    r_q   <= {r_q[NW-2:0], 1'b0};
                end
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;
endmodule

// ===== hw/rtl/safezone_stop_tracker_top.sv =====
// ----------------------------------------------------------------------------
// safezone_stop_tracker_top: safe zone stop over a chain of penetration cells
//
// Input channel (i_in_valid / o_in_stall) carries one price bar per
// transaction; output channel (o_out_valid / i_out_stall) carries at most
// one stop per bar. Results appear from bar lookback+1 of a series on.
// Configuration writes (i_cfg_valid / o_cfg_ready) set lookback, hold,
// coefficient and side; write them only while the block is idle.
// Per emitting bar: the cell chain rotates once around its LOOKBACK_MAX
// stages to accumulate the window, then two bit-serial dividers run in
// parallel, then a multiply, a saturate, and a sweep over h = min(hold,
// history fill) entries. The result is then written to the output register,
// the update step follows and the next bar is taken after it. A bar that
// emits nothing goes straight from the window sum to the update step.
// One bar is processed at a time. The result sits in an output register;
// a new bar is taken while it waits, but its result is not written until
// the register is free, and the input stalls meanwhile.
// Reset restores the register defaults and clears the series state and the
// output valid flag.
// ----------------------------------------------------------------------------
module safezone_stop_tracker_top #(
    parameter int LOOKBACK_MAX   = 64,
    parameter int HOLD_MAX       = 16,
    parameter int PRICE_BITS     = 31,
    parameter int COEF_FRAC_BITS = 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  sst_pkg::t_in_item i_in_data,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output sst_pkg::t_out_item o_out_data,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [1:0]        i_cfg_index,
    input  logic [15:0]       i_cfg_data
);
    localparam int PW  = PRICE_BITS;
    localparam int LW  = $clog2(LOOKBACK_MAX + 1);   // counts 0..LOOKBACK_MAX
    localparam int IW  = $clog2(LOOKBACK_MAX + 3);   // bar index up to lb+2
    localparam int SW  = PW + LW;                    // window sum
    localparam int HW  = $clog2(HOLD_MAX + 1);
    localparam int HA  = (HOLD_MAX > 1) ? $clog2(HOLD_MAX) : 1;
    localparam int MW  = SW + 16;                    // product width
    localparam logic signed [31:0] SMAX = 32'sh7FFFFFFF;
    localparam logic signed [31:0] SMIN = 32'sh80000000;

    typedef enum logic [7:0] {
        ST_IDLE  = 8'b00000001,
        ST_SUM   = 8'b00000010,
        ST_DIV   = 8'b00000100,
        ST_MUL   = 8'b00001000,
        ST_SAT   = 8'b00010000,
        ST_HOLD  = 8'b00100000,
        ST_EMIT  = 8'b01000000,
        ST_UPD   = 8'b10000000
    } t_state;

    t_state r_state;

    // configuration registers
    logic [6:0]  r_lookback;
    logic [4:0]  r_hold;
    logic [15:0] r_coef;
    logic        r_side;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lookback <= 7'd10;
            r_hold     <= 5'd2;
            r_coef     <= 16'd640;
            r_side     <= 1'b0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                sst_pkg::REG_LOOKBACK: r_lookback <= i_cfg_data[6:0];
                sst_pkg::REG_HOLD:     r_hold     <= i_cfg_data[4:0];
                sst_pkg::REG_COEF:     r_coef     <= i_cfg_data;
                sst_pkg::REG_SIDE:     r_side     <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // effective lookback and hold
    logic [LW-1:0] w_lb;
    logic [HW-1:0] w_hb;
    always_comb begin
        if (r_lookback == 7'd0)                           w_lb = LW'(1);
        else if (32'(r_lookback) > LOOKBACK_MAX)          w_lb = LW'(LOOKBACK_MAX);
        else                                              w_lb = LW'(r_lookback);
        if (32'(r_hold) > HOLD_MAX)                       w_hb = HW'(HOLD_MAX);
        else                                              w_hb = HW'(r_hold);
    end

    // bar-level state
    logic [PW-1:0] r_plow, r_phigh, r_low, r_high;
    logic [IW-1:0] r_bidx;
    logic [LW-1:0] r_rfill;
    logic [HW-1:0] r_hfill;
    logic [HA-1:0] r_hpos;
    logic [LW-1:0] r_step;
    logic [SW-1:0] r_dsum, r_usum;
    logic [LW-1:0] r_dcnt, r_ucnt;
    logic [MW-1:0] r_dprod, r_uprod;
    logic signed [31:0] r_rlong, r_rshort, r_hlong, r_hshort;
    logic          r_ov;
    sst_pkg::t_out_item r_out;

    // this bar produces a result
    logic          w_emit_bar;
    assign w_emit_bar = (32'(r_bidx) >= 32'(w_lb) + 32'd1);

    // cell chain: stage 0 is the newest
    sst_pkg::t_cell_ctl w_ctl;
    logic [PW-1:0] w_dn [LOOKBACK_MAX];
    logic [PW-1:0] w_up [LOOKBACK_MAX];
    logic [PW-1:0] w_dn_in, w_up_in;
    logic          w_accept;

    assign o_in_stall = (r_state != ST_IDLE);
    assign w_accept   = i_in_valid && !o_in_stall;

    always_comb begin
        w_ctl.rotate = (r_state == ST_SUM) && w_emit_bar;
        w_ctl.shift  = (r_state == ST_UPD) && (r_bidx >= IW'(2));
        if (w_ctl.rotate) begin
            w_dn_in = w_dn[LOOKBACK_MAX-1];
            w_up_in = w_up[LOOKBACK_MAX-1];
        end else begin
            w_dn_in = (r_plow > r_low)   ? r_plow - r_low   : '0;
            w_up_in = (r_high > r_phigh) ? r_high - r_phigh : '0;
        end
    end

    genvar g;
    generate
        for (g = 0; g < LOOKBACK_MAX; g++) begin : g_cell
            sst_pen_cell #(.W(PW)) u_cell (
                .i_clk (i_clk),
                .i_ctl (w_ctl),
                .i_dn  ((g == 0) ? w_dn_in : w_dn[(g == 0) ? 0 : g-1]),
                .i_up  ((g == 0) ? w_up_in : w_up[(g == 0) ? 0 : g-1]),
                .o_dn  (w_dn[g]),
                .o_up  (w_up[g])
            );
        end
    endgenerate

    // window length during the sweep
    logic [LW-1:0] w_win;
    assign w_win = (r_rfill < w_lb) ? r_rfill : w_lb;

    // dividers
    logic          r_dstart;
    logic          w_ddone, w_udone;
    logic [SW-1:0] w_dq, w_uq;

    sst_divider #(.NW(SW), .DW(LW)) u_ddiv (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(r_dstart),
        .i_num(r_dsum), .i_den(r_dcnt), .o_done(w_ddone), .o_quot(w_dq)
    );
    sst_divider #(.NW(SW), .DW(LW)) u_udiv (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(r_dstart),
        .i_num(r_usum), .i_den(r_ucnt), .o_done(w_udone), .o_quot(w_uq)
    );

    // history memory, one entry read per cycle
    logic signed [31:0] r_lhist [HOLD_MAX];
    logic signed [31:0] r_shist [HOLD_MAX];
    logic signed [31:0] r_lrd, r_srd;
    logic [HW-1:0]      r_hstep;
    logic               r_rdv;
    logic [HW-1:0]      w_hcnt;
    logic [31:0]        w_hidx;
    logic [HA-1:0]      w_haddr;
    assign w_hcnt  = (r_hfill < w_hb) ? r_hfill : w_hb;
    // entry hstep back from the newest, wrapped once
    assign w_hidx  = 32'(r_hpos) + 32'(HOLD_MAX) - 32'd1 - 32'(r_hstep);
    assign w_haddr = (w_hidx >= 32'(HOLD_MAX)) ? HA'(w_hidx - 32'(HOLD_MAX))
                                               : HA'(w_hidx);

    always_ff @(posedge i_clk) begin
        r_lrd <= r_lhist[w_haddr];
        r_srd <= r_shist[w_haddr];
        if (r_state == ST_EMIT) begin
            r_lhist[r_hpos] <= r_rlong;
            r_shist[r_hpos] <= r_rshort;
        end
    end

    // offsets and saturation
    logic [MW-COEF_FRAC_BITS-1:0] w_doff, w_uoff;
    logic signed [MW+1:0] w_lv, w_sv;
    assign w_doff = r_dprod[MW-1:COEF_FRAC_BITS];
    assign w_uoff = r_uprod[MW-1:COEF_FRAC_BITS];
    assign w_lv = $signed({2'b00, MW'(r_plow)}) - $signed({2'b00, MW'(w_doff)});
    assign w_sv = $signed({2'b00, MW'(r_phigh)}) + $signed({2'b00, MW'(w_uoff)});

    logic [IW-1:0] w_bnext;
    assign w_bnext = ((32'(r_bidx) + 1) < (32'(w_lb) + 2)) ? r_bidx + 1'b1
                                                            : IW'(32'(w_lb) + 2);

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_plow   <= '0;
            r_phigh  <= '0;
            r_bidx   <= '0;
            r_rfill  <= '0;
            r_hfill  <= '0;
            r_hpos   <= '0;
            r_ov     <= 1'b0;
            r_dstart <= 1'b0;
        end else begin
            // dividers start after the last sweep step
            r_dstart <= (r_state == ST_SUM) && w_emit_bar &&
                        (32'(r_step) == LOOKBACK_MAX - 1);
            // output register: load in ST_EMIT when free, drop on transfer
            if (r_state == ST_EMIT && (!r_ov || !i_out_stall)) r_ov <= 1'b1;
            else if (r_ov && !i_out_stall)                     r_ov <= 1'b0;
            case (r_state)
                ST_IDLE: begin
                    if (w_accept) begin
                        r_low  <= i_in_data.bar_low;
                        r_high <= i_in_data.bar_high;
                        if (i_in_data.series_start) begin
                            r_plow  <= '0;
                            r_phigh <= '0;
                            r_bidx  <= '0;
                            r_rfill <= '0;
                            r_hfill <= '0;
                            r_hpos  <= '0;
                        end
                        r_step <= '0;
                        r_dsum <= '0; r_usum <= '0;
                        r_dcnt <= '0; r_ucnt <= '0;
                        r_state <= ST_SUM;
                    end
                end
                ST_SUM: begin
                    if (!w_emit_bar) begin
                        r_state <= ST_UPD;
                    end else begin
                        // rotating: element at the tail is window entry
                        // LOOKBACK_MAX - r_step counted from newest
                        if (32'(r_step) >= LOOKBACK_MAX - 32'(w_win)) begin
                            if (w_dn[LOOKBACK_MAX-1] != '0) begin
                                r_dsum <= r_dsum + SW'(w_dn[LOOKBACK_MAX-1]);
                                r_dcnt <= r_dcnt + 1'b1;
                            end
                            if (w_up[LOOKBACK_MAX-1] != '0) begin
                                r_usum <= r_usum + SW'(w_up[LOOKBACK_MAX-1]);
                                r_ucnt <= r_ucnt + 1'b1;
                            end
                        end
                        r_step <= r_step + 1'b1;
                        if (32'(r_step) == LOOKBACK_MAX - 1) begin
                            r_state  <= ST_DIV;
                        end
                    end
                end
                ST_DIV: begin
                    if (w_ddone && w_udone) r_state <= ST_MUL;
                end
                ST_MUL: begin
                    r_dprod <= (r_dcnt == '0) ? '0 : MW'(w_dq) * MW'(r_coef);
                    r_uprod <= (r_ucnt == '0) ? '0 : MW'(w_uq) * MW'(r_coef);
                    r_state <= ST_SAT;
                end
                ST_SAT: begin
                    r_rlong  <= (w_lv > $signed((MW+2)'(SMAX))) ? SMAX :
                                (w_lv < $signed({{(MW-30){1'b1}}, 32'h80000000})) ? SMIN
                                : 32'(w_lv);
                    r_rshort <= (w_sv > $signed((MW+2)'(SMAX))) ? SMAX : 32'(w_sv);
                    r_hstep  <= '0;
                    r_rdv    <= 1'b0;
                    r_state  <= ST_HOLD;
                end
                ST_HOLD: begin
                    if (!r_rdv) begin
                        r_hlong  <= r_rlong;
                        r_hshort <= r_rshort;
                    end else if (w_hcnt != '0) begin
                        if (r_lrd > r_hlong)  r_hlong  <= r_lrd;
                        if (r_srd < r_hshort) r_hshort <= r_srd;
                    end
                    if (r_rdv && r_hstep >= w_hcnt) begin
                        r_state <= ST_EMIT;
                    end else begin
                        // address presented this cycle is read next cycle
                        r_rdv   <= 1'b1;
                        if (r_rdv) r_hstep <= r_hstep + 1'b1;
                    end
                end
                ST_EMIT: begin
                    if (!r_ov || !i_out_stall) begin
                        r_out.stop_level <= r_side ? r_hshort : r_hlong;
                        r_out.raw_stop   <= r_side ? r_rshort : r_rlong;
                        r_hpos  <= (32'(r_hpos) == HOLD_MAX - 1) ? '0 : r_hpos + 1'b1;
                        if (32'(r_hfill) < HOLD_MAX) r_hfill <= r_hfill + 1'b1;
                        r_state <= ST_UPD;
                    end
                end
                ST_UPD: begin
                    if (r_bidx >= IW'(2) && 32'(r_rfill) < LOOKBACK_MAX)
                        r_rfill <= r_rfill + 1'b1;
                    r_plow  <= r_low;
                    r_phigh <= r_high;
                    r_bidx  <= w_bnext;
                    r_state <= ST_IDLE;
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign o_out_valid = r_ov;
    assign o_out_data  = r_out;

`ifndef SYNTHESIS
    a_in_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_state == ST_SUM)) else $error("accept did not start sweep");
    a_hold_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_out_data)))
        else $error("stalled result changed");
    a_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_hfill) <= HOLD_MAX) else $error("history fill overflow");
    a_bidx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_rfill) <= LOOKBACK_MAX) else $error("ring fill overflow");
`endif
endmodule

// ===== sim/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top: safe zone stop tracker testbench
// Drives price bars with random idling and stalls, predicts the held and raw
// stops in a local model of the window and hold logic, and compares each
// output transaction field by field in order.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int LB_MAX    = 64;
    localparam int HOLD_CAP  = 16;
    localparam int FRAC      = 8;
    localparam int BAR_SLACK = 300;
    localparam int HOLD_OFF_LEN = 3000;
    localparam longint CYCLE_LIMIT = 3000000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_in_valid = 1'b0;
    logic o_in_stall;
    sst_pkg::t_in_item i_in_data = '0;
    logic o_out_valid;
    logic i_out_stall = 1'b0;
    sst_pkg::t_out_item o_out_data;
    logic i_cfg_valid = 1'b0;
    logic o_cfg_ready;
    logic [1:0] i_cfg_index = '0;
    logic [15:0] i_cfg_data = '0;

    safezone_stop_tracker_top dut (.*);

    always #4 i_clk = ~i_clk;

    // register copies
    int unsigned lookback_reg, hold_reg, coef_reg, side_reg;
    // series state
    longint unsigned prev_low, prev_high;
    int unsigned bar_cnt, ring_wr, ring_cnt, hist_wr, hist_cnt;
    longint unsigned down_ring [LB_MAX];
    longint unsigned up_ring [LB_MAX];
    int long_hist [HOLD_CAP];
    int short_hist [HOLD_CAP];

    sst_pkg::t_out_item stop_queue[$];
    int errors = 0;
    int send_idle_pct = 0;
    int stall_pct = 0;
    int hold_off_req = 0;
    int hold_off_seen = 0;
    int hold_off_left = 0;
    longint cycle_cnt = 0;

    function automatic longint unsigned noise_offset(longint unsigned sum, int unsigned cnt);
        longint unsigned off;
        if (cnt == 0) return 0;
        off = ((sum / cnt) * coef_reg) >> FRAC;
        return (off > (64'd1 << 62)) ? (64'd1 << 62) : off;
    endfunction

    function automatic int clamp_sub(longint unsigned base, longint unsigned off);
        if (off >= base) begin
            if (off - base >= 64'h8000_0000) return 32'h8000_0000;
            return -int'(off - base);
        end
        return (base - off > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : int'(base - off);
    endfunction

    function automatic int clamp_add(longint unsigned base, longint unsigned off);
        return (base + off > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : int'(base + off);
    endfunction

    task automatic clear_series();
        prev_low = 0; prev_high = 0; bar_cnt = 0;
        ring_wr = 0; ring_cnt = 0; hist_wr = 0; hist_cnt = 0;
    endtask

    // stop prediction for one accepted bar
    task automatic predict_stop(sst_pkg::t_in_item bar);
        int unsigned lb, hb, w, h, k, n, dcnt, ucnt;
        longint unsigned dsum, usum;
        int raw_l, raw_s, held_l, held_s;
        sst_pkg::t_out_item res;
        if (bar.series_start) clear_series();
        lb = (lookback_reg < 1) ? 1 : (lookback_reg > LB_MAX ? LB_MAX : lookback_reg);
        hb = (hold_reg > HOLD_CAP) ? HOLD_CAP : hold_reg;
        n = bar_cnt;
        if (n >= lb + 1) begin
            w = (ring_cnt < lb) ? ring_cnt : lb;
            dsum = 0; usum = 0; dcnt = 0; ucnt = 0;
            for (int i = 1; i <= w; i++) begin
                k = (ring_wr + LB_MAX - i) % LB_MAX;
                if (down_ring[k] != 0) begin dsum += down_ring[k]; dcnt++; end
                if (up_ring[k] != 0) begin usum += up_ring[k]; ucnt++; end
            end
            raw_l = clamp_sub(prev_low, noise_offset(dsum, dcnt));
            raw_s = clamp_add(prev_high, noise_offset(usum, ucnt));
            held_l = raw_l; held_s = raw_s;
            h = (hist_cnt < hb) ? hist_cnt : hb;
            for (int i = 1; i <= h; i++) begin
                k = (hist_wr + HOLD_CAP - i) % HOLD_CAP;
                if (long_hist[k] > held_l) held_l = long_hist[k];
                if (short_hist[k] < held_s) held_s = short_hist[k];
            end
            long_hist[hist_wr] = raw_l;
            short_hist[hist_wr] = raw_s;
            hist_wr = (hist_wr + 1) % HOLD_CAP;
            if (hist_cnt < HOLD_CAP) hist_cnt++;
            res.stop_level = side_reg ? held_s : held_l;
            res.raw_stop = side_reg ? raw_s : raw_l;
            stop_queue.push_back(res);
        end
        if (n >= 2) begin
            down_ring[ring_wr] = (prev_low > bar.bar_low) ? prev_low - bar.bar_low : 0;
            up_ring[ring_wr] = (bar.bar_high > prev_high) ? bar.bar_high - prev_high : 0;
            ring_wr = (ring_wr + 1) % LB_MAX;
            if (ring_cnt < LB_MAX) ring_cnt++;
        end
        prev_low = bar.bar_low;
        prev_high = bar.bar_high;
        bar_cnt = (n + 1 < lb + 2) ? n + 1 : lb + 2;
    endtask

    // one bar transaction, with random sender idling
    task automatic send_bar(logic [30:0] lo, logic [30:0] hi, logic start);
        @(posedge i_clk);
        while ($urandom_range(99) < send_idle_pct) @(posedge i_clk);
        i_in_valid <= 1'b1;
        i_in_data <= '{bar_low: lo, bar_high: hi, series_start: start};
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        predict_stop('{bar_low: lo, bar_high: hi, series_start: start});
        i_in_valid <= 1'b0;
    endtask

    task automatic drain();
        while (stop_queue.size() != 0) @(posedge i_clk);
        repeat (BAR_SLACK) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [15:0] val);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        case (idx)
            sst_pkg::REG_LOOKBACK: lookback_reg = val[6:0];
            sst_pkg::REG_HOLD:     hold_reg = val[4:0];
            sst_pkg::REG_COEF:     coef_reg = val;
            sst_pkg::REG_SIDE:     side_reg = val[0];
            default: ;
        endcase
    endtask

    task automatic setup(int unsigned lb, int unsigned hb, int unsigned cf, int unsigned sd);
        drain();
        write_reg(sst_pkg::REG_LOOKBACK, 16'(lb));
        write_reg(sst_pkg::REG_HOLD, 16'(hb));
        write_reg(sst_pkg::REG_COEF, 16'(cf));
        write_reg(sst_pkg::REG_SIDE, 16'(sd));
    endtask

    // random bar near a moving price; occasional extremes
    task automatic random_bars(int count, int unsigned restart_pct);
        logic [30:0] base, lo, hi;
        base = 31'($urandom_range(32'h7FFF_0000, 1000));
        for (int i = 0; i < count; i++) begin
            case ($urandom_range(9))
                0: begin lo = 31'($urandom); hi = 31'($urandom); end
                1: begin lo = '0; hi = 31'h7FFF_FFFF; end
                default: begin
                    base = 31'(32'(base) + $urandom_range(200) - 32'd100);
                    lo = 31'(32'(base) - $urandom_range(150));
                    hi = 31'(32'(base) + $urandom_range(150));
                end
            endcase
            send_bar(lo, hi, (i == 0) || ($urandom_range(99) < restart_pct));
        end
    endtask

    task automatic test_directed();
        setup(3, 2, 640, 0);
        send_bar(100, 200, 1);
        send_bar(90, 210, 0);
        send_bar(80, 230, 0);
        send_bar(80, 230, 0);
        send_bar(0, 31'h7FFF_FFFF, 0);
        send_bar(31'h7FFF_FFFF, 0, 0);
        send_bar(50, 60, 0);
        setup(3, 2, 65535, 1);
        send_bar(31'h7FFF_FFFF, 31'h7FFF_FFFF, 1);
        send_bar(0, 0, 0);
        send_bar(31'h7FFF_FFFF, 31'h7FFF_FFFF, 0);
        send_bar(0, 0, 0);
        send_bar(5, 31'h7FFF_FFFF, 0);
        // zero lookback, oversized lookback and hold
        setup(0, 31, 0, 0);
        send_bar(10, 20, 1);
        send_bar(5, 25, 0);
        send_bar(7, 21, 0);
        send_bar(3, 30, 0);
        setup(127, 17, 256, 1);
        random_bars(8, 0);
    endtask

    task automatic test_random_phases();
        setup(10, 2, 640, 0);
        random_bars(60, 2);
        send_idle_pct = 88;
        setup(1, 0, 512, 1);
        random_bars(60, 3);
        send_idle_pct = 0; stall_pct = 88;
        setup(5, 16, 1000, 0);
        random_bars(60, 2);
        send_idle_pct = 20; stall_pct = 20;
        setup(64, 4, 300, 1);
        random_bars(90, 0);
        send_idle_pct = 0; stall_pct = 0;
        setup(2, 1, 65535, 0);
        random_bars(60, 5);
    endtask

    // lookback change inside a series, no restart
    task automatic test_lookback_change();
        setup(8, 3, 640, 0);
        random_bars(20, 0);
        drain();
        write_reg(sst_pkg::REG_LOOKBACK, 16'd3);
        for (int i = 0; i < 10; i++)
            send_bar(31'($urandom_range(2000, 1000)), 31'($urandom_range(3000, 2000)), 1'b0);
        drain();
        write_reg(sst_pkg::REG_LOOKBACK, 16'd12);
        for (int i = 0; i < 15; i++)
            send_bar(31'($urandom_range(2000, 1000)), 31'($urandom_range(3000, 2000)), 1'b0);
    endtask

    // long receiver hold-off while bars keep coming, then a full pause
    task automatic test_backpressure();
        setup(1, 2, 640, 1);
        hold_off_req++;
        random_bars(30, 0);
        while (stop_queue.size() != 0) @(posedge i_clk);
        random_bars(10, 0);
    endtask

    // receiver stall generation
    always @(posedge i_clk) begin
        if (hold_off_req != hold_off_seen) begin
            hold_off_seen <= hold_off_req;
            hold_off_left <= HOLD_OFF_LEN;
            i_out_stall <= 1'b1;
        end else if (hold_off_left > 0) begin
            hold_off_left <= hold_off_left - 1;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    // result checking
    always @(posedge i_clk) begin
        sst_pkg::t_out_item want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (stop_queue.size() == 0) begin
                $error("unexpected result stop_level=%0d raw_stop=%0d",
                       o_out_data.stop_level, o_out_data.raw_stop);
                errors++;
            end else begin
                want = stop_queue.pop_front();
                if (o_out_data.stop_level !== want.stop_level) begin
                    $error("stop_level expected %0d actual %0d", want.stop_level,
                           o_out_data.stop_level);
                    errors++;
                end
                if (o_out_data.raw_stop !== want.raw_stop) begin
                    $error("raw_stop expected %0d actual %0d", want.raw_stop,
                           o_out_data.raw_stop);
                    errors++;
                end
            end
        end
    end

    // run limit
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("[safezone_stop_tracker_top] ERROR");
            $finish;
        end
    end

    initial begin
        lookback_reg = 10; hold_reg = 2; coef_reg = 640; side_reg = 0;
        clear_series();
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_random_phases();
        test_lookback_change();
        test_backpressure();
        drain();
        if (errors == 0 && stop_queue.size() == 0) begin
            $display("[safezone_stop_tracker_top] OK");
        end else begin
            $display("[safezone_stop_tracker_top] ERROR");
        end
        $finish;
    end
endmodule
